### rtl/pie_pkg.sv
`timescale 1ns / 1ps
package pie_pkg;

    localparam int DEPTH   = 32;
    localparam int WORD_W  = 32;
    localparam int POS_W   = 6;
    localparam int CAP_W   = 6;
    localparam int OUT_CNT_W = 6;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    // compare width: holds position, count, capacity and index + 1
    localparam int CMP_W   = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(32);

    typedef logic signed [WORD_W-1:0] word_t;

    typedef enum logic [2:0] {
        CMD_PUSH   = 3'd0,
        CMD_POP    = 3'd1,
        CMD_INSERT = 3'd2,
        CMD_ERASE  = 3'd3,
        CMD_READ   = 3'd4,
        CMD_CLEAR  = 3'd5,
        CMD_FILL   = 3'd6,
        CMD_NONE   = 3'd7
    } cmd_e;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_BADPOS = 2'd3
    } status_e;

    // broadcast to every cell of the row
    typedef struct packed {
        cmd_e              op;
        logic [CMP_W-1:0]  pos;
        logic [CMP_W-1:0]  count;
        logic [CMP_W-1:0]  cap;
        word_t             value;
    } cell_ctl_t;

endpackage

### rtl/pie_if.sv
`timescale 1ns / 1ps
interface pie_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [2:0]                    command;
    logic [pie_pkg::POS_W-1:0]     position;
    logic signed [pie_pkg::WORD_W-1:0] value;

    modport source (output valid, output command, output position, output value,
                    input ready);
    modport sink   (input valid, input command, input position, input value,
                    output ready);
endinterface

interface pie_res_if;
    logic                              valid;
    logic                              ready;
    logic signed [pie_pkg::WORD_W-1:0] read_data;
    logic [pie_pkg::OUT_CNT_W-1:0]     entry_count;
    logic                              is_empty;
    logic [1:0]                        status;

    modport source (output valid, output read_data, output entry_count,
                    output is_empty, output status, input ready);
    modport sink   (input valid, input read_data, input entry_count,
                    input is_empty, input status, output ready);
endinterface

interface pie_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [pie_pkg::CAP_W-1:0]     capacity_limit;

    modport source (output valid, output capacity_limit, input ready);
    modport sink   (input valid, input capacity_limit, output ready);
endinterface

### rtl/pie_cell.sv
`timescale 1ns / 1ps
module pie_cell (
    input  logic                      clk,
    input  pie_pkg::cell_ctl_t        ctl,
    input  logic [pie_pkg::CMP_W-1:0] idx,
    input  pie_pkg::word_t            lower,
    input  pie_pkg::word_t            upper,
    output pie_pkg::word_t            q
);
    import pie_pkg::*;

    word_t             data_reg;
    word_t             data_next;
    logic [CMP_W-1:0]  idx_up;

    assign idx_up = idx + CMP_W'(1);

    always_comb
    begin
        data_next = data_reg;
        case (ctl.op)
            CMD_PUSH:
            begin
                if (idx == ctl.count)
                    data_next = ctl.value;
            end
            CMD_INSERT:
            begin
                if (idx == ctl.pos)
                    data_next = ctl.value;
                else if (idx > ctl.pos && idx <= ctl.count)
                    data_next = lower;
            end
            CMD_ERASE:
            begin
                if (idx >= ctl.pos && idx_up < ctl.count)
                    data_next = upper;
            end
            CMD_FILL:
            begin
                if (idx < ctl.cap)
                    data_next = ctl.value;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign q = data_reg;

endmodule

### rtl/positional_insert_erase_array_top.sv
`timescale 1ns / 1ps
// ordered array of signed 32-bit words held in a row of DEPTH cells, with an
// entry count; commands push, pop, insert, erase, read, clear and fill. one
// item is taken per clock, and its result appears in the output register on
// the next clock; the input stalls only while that register holds a result
// the sink has not yet taken. insert moves entries from the position up and
// erase those above it down by one place at once, each cell loading from its
// neighbour, so the rate is set by the row update and the read select over
// the cells. there is no clearing pass after reset: the count starts at zero
// and only entries below it are ever read. the capacity register is taken at
// any time with ready held high, and caps the count at min(limit, DEPTH)
module positional_insert_erase_array_top (
    input  logic       clk,
    input  logic       rst_n,
    pie_cmd_if.sink    cmd,
    pie_res_if.source  res,
    pie_cfg_if.sink    cfg
);
    import pie_pkg::*;

    // configuration
    logic [CAP_W-1:0]  cap_reg;
    logic [CMP_W-1:0]  cap_ext;
    logic [CMP_W-1:0]  eff_cap;

    // array state
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [CMP_W-1:0]  count_ext;
    logic [CMP_W-1:0]  pos_ext;
    word_t             cell_q [DEPTH];
    cell_ctl_t         ctl;

    // item decode
    logic              accept;
    cmd_e              op;
    status_e           status_c;
    word_t             rdata_c;
    logic [CNT_W-1:0]  count_c;

    // output register
    logic              res_valid_reg;
    logic              res_valid_next;
    word_t             rdata_reg;
    logic [CNT_W-1:0]  rcount_reg;
    status_e           status_reg;

    // config write port never stalls
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cap_reg <= CAP_RESET;
        else if (cfg.valid)
            cap_reg <= cfg.capacity_limit;
    end

    assign cap_ext = CMP_W'(cap_reg);
    assign eff_cap = (cap_ext > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : cap_ext;

    // input side stalls only when a result is waiting and not taken
    assign cmd.ready = !res_valid_reg || res.ready;
    assign accept    = cmd.valid && cmd.ready;

    assign op        = cmd_e'(cmd.command);
    assign count_ext = CMP_W'(count_reg);
    assign pos_ext   = CMP_W'(cmd.position);

    // status, new count and read data for the item on the input
    always_comb
    begin
        status_c = ST_OK;
        rdata_c  = '0;
        count_c  = count_reg;
        case (op)
            CMD_PUSH:
            begin
                if (count_ext >= eff_cap)
                    status_c = ST_FULL;
                else
                    count_c = count_reg + CNT_W'(1);
            end
            CMD_POP:
            begin
                if (count_reg == '0)
                    status_c = ST_EMPTY;
                else
                    count_c = count_reg - CNT_W'(1);
            end
            CMD_INSERT:
            begin
                if (pos_ext > count_ext)
                    status_c = ST_BADPOS;
                else if (count_ext >= eff_cap)
                    status_c = ST_FULL;
                else
                    count_c = count_reg + CNT_W'(1);
            end
            CMD_ERASE:
            begin
                if (pos_ext >= count_ext)
                    status_c = ST_BADPOS;
                else
                    count_c = count_reg - CNT_W'(1);
            end
            CMD_READ:
            begin
                // position below count, so the low index bits address a cell
                if (pos_ext >= count_ext)
                    status_c = ST_BADPOS;
                else
                    rdata_c = cell_q[pos_ext[IDX_W-1:0]];
            end
            CMD_CLEAR:
            begin
                count_c = '0;
            end
            CMD_FILL:
            begin
                count_c = CNT_W'(eff_cap);
            end
            default:
            begin
                count_c = count_reg;
            end
        endcase
    end

    assign count_next = accept ? count_c : count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    // row control: only writing commands that passed their checks move cells
    always_comb
    begin
        ctl.op    = CMD_NONE;
        ctl.pos   = pos_ext;
        ctl.count = count_ext;
        ctl.cap   = eff_cap;
        ctl.value = cmd.value;
        if (accept && status_c == ST_OK)
        begin
            case (op)
                CMD_PUSH, CMD_INSERT, CMD_ERASE, CMD_FILL: ctl.op = op;
                default:                                   ctl.op = CMD_NONE;
            endcase
        end
    end

    // the cell row: each cell sees its lower and upper neighbour
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        word_t lower_d;
        word_t upper_d;

        if (i == 0)
        begin : g_first
            assign lower_d = '0;
        end
        else
        begin : g_lower
            assign lower_d = cell_q[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign upper_d = '0;
        end
        else
        begin : g_upper
            assign upper_d = cell_q[i+1];
        end

        pie_cell u_cell (
            .clk   (clk),
            .ctl   (ctl),
            .idx   (CMP_W'(i)),
            .lower (lower_d),
            .upper (upper_d),
            .q     (cell_q[i])
        );
    end

    // output register, refilled in the same cycle it is emptied
    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (accept)
            res_valid_next = 1'b1;
        else if (res.ready)
            res_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else
            res_valid_reg <= res_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rdata_reg  <= rdata_c;
            rcount_reg <= count_c;
            status_reg <= status_c;
        end
    end

    assign res.valid       = res_valid_reg;
    assign res.read_data   = rdata_reg;
    assign res.entry_count = OUT_CNT_W'(rcount_reg);
    assign res.is_empty    = (rcount_reg == '0);
    assign res.status      = status_reg;

endmodule

### rtl/pie_checker.sv
`timescale 1ns / 1ps
module pie_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [pie_pkg::OUT_CNT_W-1:0] out_count,
    input  logic                          out_empty,
    input  logic [1:0]                    out_status
);
    import pie_pkg::*;

    // every accepted item shows its result on the next clock
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> out_valid)
        else $error("no result after accepted item");

    // a result not taken stays offered
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result dropped while stalled");

    // empty flag agrees with the count
    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_empty == (out_count == '0)))
        else $error("empty flag and count disagree");

    // a refused pop only happens on an empty array
    a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_status == ST_EMPTY) |-> out_empty)
        else $error("empty status with entries present");

endmodule

bind positional_insert_erase_array_top pie_checker u_pie_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (cmd.valid),
    .in_ready   (cmd.ready),
    .out_valid  (res.valid),
    .out_ready  (res.ready),
    .out_count  (res.entry_count),
    .out_empty  (res.is_empty),
    .out_status (res.status)
);
